/* design/mfbc_pkg.sv */
// Shared types, constants and round functions for the mini Feistel block cipher.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package mfbc_pkg;

  // Field widths.
  localparam int BLOCK_W    = 12;
  localparam int HALF_W     = 6;
  localparam int KEY_W      = 9;
  localparam int SUBKEY_W   = 8;
  localparam int ROUNDS_W   = 5;
  localparam int MODE_W     = 2;
  localparam int OFF_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Default for the round limit parameter.
  localparam int DEFAULT_MAX_ROUNDS = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_SELECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VECTOR    = 3'd4;

  // Chaining mode codes; the unused code behaves as ECB.
  localparam logic [MODE_W-1:0] MODE_ECB     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COUNTER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CBC     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD    = 2'd3;

  // Reset value of the round count register.
  localparam logic [ROUNDS_W-1:0] ROUND_COUNT_RST = 5'd4;

  // Last key rotation offset (offsets run 0 to 8).
  localparam logic [OFF_W-1:0] OFF_LAST = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new block and set up the round state
    logic round_en;  // apply one Feistel round
    logic finish;    // write the result register and update the chain value
  } mfbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rounds_zero;  // the configured round count is zero
    logic last_round;   // the round now applied is the final one
  } mfbc_sts_t;

  // First S-box, 4 bits to 3 bits.
  function automatic logic [2:0] sbox_one(input logic [3:0] a);
    logic [2:0] s;
    case (a)
      4'h0: s = 3'd5;
      4'h1: s = 3'd2;
      4'h2: s = 3'd1;
      4'h3: s = 3'd6;
      4'h4: s = 3'd3;
      4'h5: s = 3'd4;
      4'h6: s = 3'd7;
      4'h7: s = 3'd0;
      4'h8: s = 3'd1;
      4'h9: s = 3'd4;
      4'hA: s = 3'd6;
      4'hB: s = 3'd2;
      4'hC: s = 3'd0;
      4'hD: s = 3'd7;
      4'hE: s = 3'd5;
      default: s = 3'd3;
    endcase
    return s;
  endfunction

  // Second S-box, 4 bits to 3 bits.
  function automatic logic [2:0] sbox_two(input logic [3:0] a);
    logic [2:0] s;
    case (a)
      4'h0: s = 3'd4;
      4'h1: s = 3'd0;
      4'h2: s = 3'd6;
      4'h3: s = 3'd5;
      4'h4: s = 3'd7;
      4'h5: s = 3'd1;
      4'h6: s = 3'd3;
      4'h7: s = 3'd2;
      4'h8: s = 3'd5;
      4'h9: s = 3'd3;
      4'hA: s = 3'd0;
      4'hB: s = 3'd7;
      4'hC: s = 3'd6;
      4'hD: s = 3'd2;
      4'hE: s = 3'd1;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

  // Round key: the key rotated left by the offset, upper eight bits kept.
  function automatic logic [SUBKEY_W-1:0] sub_key(input logic [KEY_W-1:0] key,
                                                  input logic [OFF_W-1:0] off);
    logic [2*KEY_W-1:0] dbl;
    dbl = {key, key} << off;
    return dbl[2*KEY_W-1:KEY_W+1];
  endfunction

  // One Feistel round: new block is R followed by L XOR F(R, K).
  function automatic logic [BLOCK_W-1:0] feistel_round(input logic [BLOCK_W-1:0] x,
                                                       input logic [SUBKEY_W-1:0] k);
    logic [HALF_W-1:0]   l;
    logic [HALF_W-1:0]   r;
    logic [SUBKEY_W-1:0] e;
    logic [SUBKEY_W-1:0] t;
    logic [HALF_W-1:0]   f;
    l = x[BLOCK_W-1:HALF_W];
    r = x[HALF_W-1:0];
    e = {r[5], r[4], r[2], r[3], r[2], r[3], r[1], r[0]};
    t = e ^ k;
    f = {sbox_one(t[7:4]), sbox_two(t[3:0])};
    return {r, l ^ f};
  endfunction

  // Exchange the two halves of a block.
  function automatic logic [BLOCK_W-1:0] swap_halves(input logic [BLOCK_W-1:0] x);
    return {x[HALF_W-1:0], x[BLOCK_W-1:HALF_W]};
  endfunction

  // Remainder by nine for a five-bit value, by two conditional subtractions.
  function automatic logic [OFF_W-1:0] mod_nine(input logic [ROUNDS_W-1:0] v);
    logic [ROUNDS_W-1:0] m;
    m = v;
    if (m >= 5'd18) begin
      m = m - 5'd18;
    end
    if (m >= 5'd9) begin
      m = m - 5'd9;
    end
    return m[OFF_W-1:0];
  endfunction

endpackage

/* design/mfbc_ctrl.sv */
// Controller state machine of the mini Feistel block cipher.
// Sequences block load, rounds and result write; depends on mfbc_pkg.
`timescale 1ns / 1ps

module mfbc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  mfbc_pkg::mfbc_sts_t sts_i,
  output mfbc_pkg::mfbc_cmd_t cmd_o
);
  import mfbc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       out_free;

  // The result register can take a new value when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o.load     = 1'b0;
    cmd_o.round_en = 1'b0;
    cmd_o.finish   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.rounds_zero ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.last_round) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag: set on a finished block, cleared when the transaction completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* design/mfbc_datapath.sv */
// Datapath of the mini Feistel block cipher: block, round and chain registers.
// Depends on mfbc_pkg for the round functions and command/status types.
`timescale 1ns / 1ps

module mfbc_datapath #(
  parameter int MAX_ROUNDS = mfbc_pkg::DEFAULT_MAX_ROUNDS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [mfbc_pkg::KEY_W-1:0]       cipher_key_i,
  input  logic [mfbc_pkg::ROUNDS_W-1:0]    round_count_i,
  input  logic [mfbc_pkg::MODE_W-1:0]      chain_mode_i,
  input  logic                             decrypt_select_i,
  input  logic [mfbc_pkg::BLOCK_W-1:0]     init_vector_i,
  input  logic [mfbc_pkg::BLOCK_W-1:0]     block_in_i,
  input  logic                             first_block_i,
  input  mfbc_pkg::mfbc_cmd_t              cmd_i,
  output mfbc_pkg::mfbc_sts_t              sts_o,
  output logic [mfbc_pkg::BLOCK_W-1:0]     block_out_o
);
  import mfbc_pkg::*;

  logic [BLOCK_W-1:0]  x_q;
  logic [BLOCK_W-1:0]  x_d;
  logic [BLOCK_W-1:0]  blk_q;
  logic [BLOCK_W-1:0]  chain_q;
  logic [BLOCK_W-1:0]  chain_d;
  logic [ROUNDS_W-1:0] rem_q;
  logic [ROUNDS_W-1:0] rem_d;
  logic [OFF_W-1:0]    off_q;
  logic [OFF_W-1:0]    off_d;
  logic [BLOCK_W-1:0]  out_q;
  logic [BLOCK_W-1:0]  out_d;

  logic [ROUNDS_W-1:0] rounds_eff;
  logic [BLOCK_W-1:0]  chain_eff;
  logic                chained;
  logic [BLOCK_W-1:0]  core;
  logic [BLOCK_W-1:0]  result;

  // Round count saturated to the configured limit.
  assign rounds_eff = (32'(round_count_i) > MAX_ROUNDS) ? ROUNDS_W'(MAX_ROUNDS)
                                                        : round_count_i;

  // Chain value after an optional reload from the starting vector.
  assign chain_eff = first_block_i ? init_vector_i : chain_q;
  assign chained   = (chain_mode_i == MODE_COUNTER) || (chain_mode_i == MODE_CBC);

  assign sts_o.rounds_zero = (rounds_eff == '0);
  assign sts_o.last_round  = (rem_q == ROUNDS_W'(1));

  // Block register: prepared on load, advanced one round per cycle.
  always_comb begin
    x_d = x_q;
    if (cmd_i.load) begin
      if (decrypt_select_i) begin
        x_d = swap_halves(block_in_i);
      end else if (chained) begin
        x_d = block_in_i ^ chain_eff;
      end else begin
        x_d = block_in_i;
      end
    end else if (cmd_i.round_en) begin
      x_d = feistel_round(x_q, sub_key(cipher_key_i, off_q));
    end
  end

  // Round counter and key rotation offset; decryption walks the offsets backward.
  always_comb begin
    rem_d = rem_q;
    off_d = off_q;
    if (cmd_i.load) begin
      rem_d = rounds_eff;
      off_d = decrypt_select_i ? mod_nine(rounds_eff - ROUNDS_W'(1)) : '0;
    end else if (cmd_i.round_en) begin
      rem_d = rem_q - ROUNDS_W'(1);
      if (decrypt_select_i) begin
        off_d = (off_q == '0) ? OFF_LAST : off_q - OFF_W'(1);
      end else begin
        off_d = (off_q == OFF_LAST) ? '0 : off_q + OFF_W'(1);
      end
    end
  end

  // Result and chain update at the end of a block.
  assign core   = decrypt_select_i ? swap_halves(x_q) : x_q;
  assign result = (decrypt_select_i && chained) ? (core ^ chain_q) : core;

  always_comb begin
    chain_d = chain_q;
    out_d   = out_q;
    if (cmd_i.load) begin
      chain_d = chain_eff;
    end else if (cmd_i.finish) begin
      out_d = result;
      case (chain_mode_i)
        MODE_COUNTER: chain_d = chain_q + BLOCK_W'(1);
        MODE_CBC:     chain_d = decrypt_select_i ? blk_q : result;
        default:      chain_d = chain_q;
      endcase
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
      rem_q   <= '0;
      off_q   <= '0;
    end else begin
      chain_q <= chain_d;
      rem_q   <= rem_d;
      off_q   <= off_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    out_q <= out_d;
    if (cmd_i.load) begin
      blk_q <= block_in_i;
    end
  end

  assign block_out_o = out_q;

endmodule

/* design/mini_feistel_block_cipher_unit.sv */
// Top level of the mini Feistel block cipher: configuration registers,
// controller and datapath. Depends on mfbc_pkg, mfbc_ctrl and mfbc_datapath.
`timescale 1ns / 1ps

// Usage:
// Configuration is written over the cfg channel (index and data); it is always
// ready, and writes to indexes past the register list are ignored. Write it
// only while the block is idle.
// A block enters on the input channel when in_valid_i is high and in_stall_o
// is low. The block is held while its rounds run: one Feistel round per cycle
// through a single shared round unit, for n effective rounds (the round
// count, saturated to MAX_ROUNDS), and in_stall_o stays high until its result
// is written to the output register, so a new block is taken only after the
// previous one is through. The chaining modes use the chain register left by
// the previous block, or the starting vector when first_block_i is high.
// The result sits in an output register; a new block may be accepted while it
// waits. If the receiver keeps out_stall_i high, the next block finishes its
// rounds and then waits until the register is taken.
// Reset clears the chain register, the handshake state and the configuration
// (round count to 4, everything else to zero).

module mini_feistel_block_cipher_unit #(
  parameter int MAX_ROUNDS = mfbc_pkg::DEFAULT_MAX_ROUNDS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mfbc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mfbc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mfbc_pkg::BLOCK_W-1:0]       block_in_i,
  input  logic                               first_block_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mfbc_pkg::BLOCK_W-1:0]       block_out_o
);
  import mfbc_pkg::*;

  logic [KEY_W-1:0]    cipher_key_q;
  logic [ROUNDS_W-1:0] round_count_q;
  logic [MODE_W-1:0]   chain_mode_q;
  logic                decrypt_select_q;
  logic [BLOCK_W-1:0]  init_vector_q;
  logic                cfg_we;

  mfbc_cmd_t cmd;
  mfbc_sts_t sts;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q     <= '0;
      round_count_q    <= ROUND_COUNT_RST;
      chain_mode_q     <= MODE_ECB;
      decrypt_select_q <= 1'b0;
      init_vector_q    <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_CIPHER_KEY:     cipher_key_q     <= cfg_data_i[KEY_W-1:0];
        REG_ROUND_COUNT:    round_count_q    <= cfg_data_i[ROUNDS_W-1:0];
        REG_CHAIN_MODE:     chain_mode_q     <= cfg_data_i[MODE_W-1:0];
        REG_DECRYPT_SELECT: decrypt_select_q <= cfg_data_i[0];
        REG_INIT_VECTOR:    init_vector_q    <= cfg_data_i[BLOCK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Controller.
  mfbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  mfbc_datapath #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cipher_key_i     (cipher_key_q),
    .round_count_i    (round_count_q),
    .chain_mode_i     (chain_mode_q),
    .decrypt_select_i (decrypt_select_q),
    .init_vector_i    (init_vector_q),
    .block_in_i       (block_in_i),
    .first_block_i    (first_block_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .block_out_o      (block_out_o)
  );

endmodule
